// ===== src/sitrt_pkg.sv =====
// Shared constants, command/status types and the digit-to-character map.
`default_nettype none

package sitrt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int CODE_W         = 7;
  localparam int OUT_TDATA_W    = 8;
  localparam int STEP_BITS      = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMALS    = 6'd10;

  localparam logic [CODE_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CODE_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CODE_W-1:0] CHAR_A     = 7'h61;

  typedef struct packed {
    logic load;       // take a new input word
    logic div_clear;  // clear remainder before next digit
    logic div_step;   // one radix division step
    logic wr_digit;   // store remainder as digit
    logic rd_digit;   // read one stored digit
    logic out_sign;   // load '-' into output register
    logic out_digit;  // load read digit into output register
    logic out_last;   // mark loaded character as last
  } sitrt_cmd_t;

  typedef struct packed {
    logic neg;
    logic q_zero;
    logic out_free;
  } sitrt_stat_t;

  function automatic logic [CODE_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CODE_W-1:0] code;
    if (d < DECIMALS) begin
      code = CHAR_ZERO + {1'b0, d};
    end else if (d < RADIX_MAX) begin
      code = CHAR_A + {1'b0, d - DECIMALS};
    end else begin
      code = CHAR_ZERO;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/signed_integer_to_radix_text_unit.sv =====
// Top level: signed integer to ASCII text in a configurable radix.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data: radix, 2..36 (others ignored)
//  in      | in        | in_tvalid/in_tready  | in_tdata: number_in (signed)
//  out     | out       | out_tvalid/out_tready| out_tdata: char_code; out_tlast: last_char
//
// Each digit is formed by the 4-bit-per-cycle divider (S_DIV) and then stored (S_WR);
// each character then passes through the digit memory read port (S_RD, S_OUT),
// after a minus sign (S_SIGN) for a negative number.
// Output stalls hold the emission; a new word is taken once the last character
// sits in the output register. Reset is synchronous; radix resets to 10.
`default_nettype none

module signed_integer_to_radix_text_unit #(
  parameter int DATA_WIDTH = sitrt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [sitrt_pkg::RADIX_W-1:0]          cfg_data,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0]  in_tdata,   // [DATA_WIDTH-1:0] number_in
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [sitrt_pkg::OUT_TDATA_W-1:0]           out_tdata,  // [6:0] char_code
  output logic                                        out_tlast
);

  sitrt_pkg::sitrt_cmd_t            cmd;
  sitrt_pkg::sitrt_stat_t           stat;
  logic [$clog2(DATA_WIDTH)-1:0]    addr;
  logic [sitrt_pkg::CODE_W-1:0]     out_code;

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(sitrt_pkg::OUT_TDATA_W - sitrt_pkg::CODE_W){1'b0}}, out_code};

  sitrt_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd),
    .addr     (addr)
  );

  sitrt_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .number_in (in_tdata[DATA_WIDTH-1:0]),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (out_code),
    .out_last  (out_tlast)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_sign || cmd.out_digit) |-> stat.out_free)
    else $error("output register loaded while a character is still pending");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_sign, cmd.out_digit}))
    else $error("sign and digit loaded in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new word taken while conversion in progress");

  a_div_excludes_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !(cmd.out_sign || cmd.out_digit || cmd.rd_digit))
    else $error("emission overlaps division");

endmodule

`default_nettype wire

// ===== src/sitrt_dp.sv =====
// Datapath: radix register, digit-serial divider, digit memory, output register.
`default_nettype none

module sitrt_dp #(
  parameter int DATA_WIDTH = sitrt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [sitrt_pkg::RADIX_W-1:0]     cfg_data,
  input  wire logic [DATA_WIDTH-1:0]             number_in,
  input  wire sitrt_pkg::sitrt_cmd_t             cmd,
  input  wire logic [$clog2(DATA_WIDTH)-1:0]     addr,
  output sitrt_pkg::sitrt_stat_t                 stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sitrt_pkg::CODE_W-1:0]           out_code,
  output logic                                   out_last
);

  localparam int PW = ((DATA_WIDTH + sitrt_pkg::STEP_BITS - 1) / sitrt_pkg::STEP_BITS)
                      * sitrt_pkg::STEP_BITS;
  localparam int RW = sitrt_pkg::RADIX_W;

  logic [RW-1:0]                 radix_r;
  logic [PW-1:0]                 q_r;
  logic [RW-1:0]                 rem_r;
  logic                          neg_r;
  logic [RW-1:0]                 digit_mem [DATA_WIDTH];
  logic [RW-1:0]                 rd_r;
  logic                          out_valid_r;
  logic [sitrt_pkg::CODE_W-1:0]  out_code_r;
  logic                          out_last_r;

  logic [DATA_WIDTH-1:0]         mag;
  logic [PW-1:0]                 q_nxt;
  logic [RW-1:0]                 rem_nxt;
  logic [RW:0]                   part;

  // Magnitude modulo 2^DATA_WIDTH; the most negative value maps to 2^(DATA_WIDTH-1).
  assign mag = number_in[DATA_WIDTH-1] ? (~number_in + 1'b1) : number_in;

  // Restoring division, STEP_BITS quotient bits per cycle.
  always_comb begin
    q_nxt = q_r;
    part  = {1'b0, rem_r};
    for (int i = 0; i < sitrt_pkg::STEP_BITS; i++) begin
      part  = {part[RW-1:0], q_nxt[PW-1]};
      q_nxt = {q_nxt[PW-2:0], 1'b0};
      if (part >= {1'b0, radix_r}) begin
        part     = part - {1'b0, radix_r};
        q_nxt[0] = 1'b1;
      end
    end
    rem_nxt = part[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= sitrt_pkg::RADIX_RESET;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop out-of-range radix writes
      if (cfg_valid && cfg_data >= sitrt_pkg::RADIX_MIN && cfg_data <= sitrt_pkg::RADIX_MAX) begin
        radix_r <= cfg_data;
      end
      if (cmd.load) begin
        neg_r <= number_in[DATA_WIDTH-1];
      end
      if (cmd.out_sign || cmd.out_digit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r   <= PW'(mag);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end else if (cmd.div_clear) begin
      rem_r <= '0;
    end
    if (cmd.out_sign || cmd.out_digit) begin
      out_code_r <= cmd.out_sign ? sitrt_pkg::CHAR_MINUS : sitrt_pkg::digit_char(rd_r);
      out_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_digit) begin
      digit_mem[addr] <= rem_r;
    end
    if (cmd.rd_digit) begin
      rd_r <= digit_mem[addr];
    end
  end

  assign stat.neg      = neg_r;
  assign stat.q_zero   = (q_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== src/sitrt_ctrl.sv =====
// Controller: sequences division steps, digit writes and reverse emission.
`default_nettype none

module sitrt_ctrl #(
  parameter int DATA_WIDTH = sitrt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire sitrt_pkg::sitrt_stat_t         stat,
  output sitrt_pkg::sitrt_cmd_t               cmd,
  output logic [$clog2(DATA_WIDTH)-1:0]       addr
);

  localparam int STEPS = (DATA_WIDTH + sitrt_pkg::STEP_BITS - 1) / sitrt_pkg::STEP_BITS;
  localparam int SW    = $clog2(STEPS);
  localparam int CW    = $clog2(DATA_WIDTH + 1);
  localparam int AW    = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WR,
    S_SIGN,
    S_RD,
    S_OUT
  } state_t;

  state_t         state_r;
  logic [SW-1:0]  step_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_dec;
  logic [CW-1:0]  cnt_inc;

  assign cnt_dec = cnt_r - CW'(1);
  assign cnt_inc = cnt_r + CW'(1);

  always_comb begin
    cmd      = '0;
    addr     = cnt_r[AW-1:0];
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_WR: begin
        cmd.wr_digit  = 1'b1;
        cmd.div_clear = 1'b1;
      end
      S_SIGN: begin
        cmd.out_sign = stat.out_free;
      end
      S_RD: begin
        cmd.rd_digit = 1'b1;
        addr         = cnt_dec[AW-1:0];
      end
      S_OUT: begin
        cmd.out_digit = stat.out_free;
        cmd.out_last  = (cnt_r == CW'(1));
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DIV;
            step_r  <= '0;
            cnt_r   <= '0;
          end
        end
        S_DIV: begin
          step_r <= step_r + SW'(1);
          if (step_r == SW'(STEPS - 1)) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          cnt_r  <= cnt_inc;
          step_r <= '0;
          // stop once the quotient runs out or the digit memory is full
          if (stat.q_zero || cnt_inc == CW'(DATA_WIDTH)) begin
            state_r <= stat.neg ? S_SIGN : S_RD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_SIGN: begin
          if (stat.out_free) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (stat.out_free) begin
            cnt_r   <= cnt_dec;
            state_r <= (cnt_r == CW'(1)) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
